>>> rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/avidmx_pkg.sv
// types and constants of the avi chunk demux
package avidmx_pkg;

  localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
  localparam logic [31:0] MAGIC_AVI  = 32'h2049_5641;
  localparam logic [31:0] MAGIC_LIST = 32'h5453_494c;
  localparam logic [31:0] MAGIC_MOVI = 32'h6976_6f6d;
  localparam logic [7:0]  VIDEO_CHAR_RESET = 8'h64;

  localparam logic [1:0] CLS_HEADER  = 2'd0;
  localparam logic [1:0] CLS_VIDEO   = 2'd1;
  localparam logic [1:0] CLS_SKIP    = 2'd2;
  localparam logic [1:0] CLS_IGNORED = 2'd3;

  localparam logic [1:0] ST_SEARCH = 2'd0;
  localparam logic [1:0] ST_MOVI   = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  localparam logic [1:0] HW_FIRST  = 2'd0;
  localparam logic [1:0] HW_SECOND = 2'd1;
  localparam logic [1:0] HW_THIRD  = 2'd2;
  localparam logic [1:0] BIW_LAST  = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_TOP_WORDS  = 3'd1,
    PH_TOP_SKIP   = 3'd2,
    PH_MOVI_WORDS = 3'd3,
    PH_MOVI_VIDEO = 3'd4,
    PH_MOVI_SKIP  = 3'd5,
    PH_DONE       = 3'd6,
    PH_REJECT     = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
    logic       stop_request;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] byte_class;
    logic       payload_last;
    logic [1:0] parse_status;
  } result_t;

  // handshake between the input register and the downstream stages
  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage

>>> rtl/avidmx_in_reg.sv
// input register stage holding one accepted word
module avidmx_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  avidmx_pkg::item_t  in_item,
  input  logic               take,
  output logic               s1_valid,
  output avidmx_pkg::item_t  s1_item
);
  import avidmx_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_stall = valid_r && !take;
  assign s1_valid = valid_r;
  assign s1_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

>>> rtl/avidmx_parser.sv
// chunk walker: parser state and per-byte classification
module avidmx_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  avidmx_pkg::stage_ctl_t ctl,
  input  avidmx_pkg::item_t      item,
  input  logic [7:0]             video_tag_char,
  output avidmx_pkg::result_t    result
);
  import avidmx_pkg::*;

  phase_t      ph_r, ph_nxt, ph;
  logic [1:0]  biw_r, biw_nxt, biw;
  logic [31:0] ws_r, ws_nxt, ws;
  logic [31:0] tag_r, tag_nxt, tag;
  logic [31:0] rem_r, rem_nxt, rem;
  logic [31:0] fpos_r, fpos_nxt, fpos;
  logic [31:0] mend_r, mend_nxt, mend;
  logic [1:0]  hwc_r, hwc_nxt, hwc;

  logic [31:0] ws_g;
  logic [1:0]  biw_g;
  logic        full;
  logic        movi_stop;
  logic [31:0] rem_dec;
  logic        fire;

  logic [1:0]  cls;
  logic        last;
  logic [1:0]  status;

  assign fire = ctl.valid && ctl.take;

  // file_start restarts from the cleared state on this very byte
  always_comb begin
    if (item.file_start) begin
      ph = PH_HEADER; biw = '0; ws = '0; tag = '0;
      rem = '0; fpos = '0; mend = '0; hwc = HW_FIRST;
    end else begin
      ph = ph_r; biw = biw_r; ws = ws_r; tag = tag_r;
      rem = rem_r; fpos = fpos_r; mend = mend_r; hwc = hwc_r;
    end
  end

  assign ws_g      = {item.data_byte, ws[31:8]};
  assign biw_g     = biw + 2'd1;
  assign full      = (biw == BIW_LAST);
  assign rem_dec   = rem - 32'd1;
  // chunk boundary inside movi: past the end or asked to stop
  assign movi_stop = (biw == '0) && (hwc == HW_FIRST) &&
                     (!(fpos < mend) || item.stop_request);

  // next state
  always_comb begin
    ph_nxt   = ph;
    biw_nxt  = biw;
    ws_nxt   = ws;
    tag_nxt  = tag;
    rem_nxt  = rem;
    fpos_nxt = fpos + 32'd1;
    mend_nxt = mend;
    hwc_nxt  = hwc;
    unique case (ph) inside
      PH_HEADER: begin
        ws_nxt  = ws_g;
        biw_nxt = biw_g;
        if (full) begin
          if (hwc == HW_FIRST) begin
            if (ws_g != MAGIC_RIFF) ph_nxt = PH_REJECT;
            else hwc_nxt = HW_SECOND;
          end else if (hwc == HW_SECOND) begin
            hwc_nxt = HW_THIRD;
          end else if (ws_g != MAGIC_AVI) begin
            ph_nxt = PH_REJECT;
          end else begin
            ph_nxt  = PH_TOP_WORDS;
            hwc_nxt = HW_FIRST;
          end
        end
      end
      PH_TOP_WORDS: begin
        ws_nxt  = ws_g;
        biw_nxt = biw_g;
        if (full) begin
          if (hwc == HW_FIRST) begin
            tag_nxt = ws_g;
            hwc_nxt = HW_SECOND;
          end else if (hwc == HW_SECOND && tag == MAGIC_LIST) begin
            rem_nxt = ws_g - 32'd4;
            hwc_nxt = HW_THIRD;
          end else if (hwc == HW_SECOND) begin
            hwc_nxt = HW_FIRST;
            if (ws_g != '0) begin
              rem_nxt = ws_g;
              ph_nxt  = PH_TOP_SKIP;
            end
          end else if (ws_g == MAGIC_MOVI) begin
            mend_nxt = fpos_nxt + rem;
            ph_nxt   = PH_MOVI_WORDS;
            hwc_nxt  = HW_FIRST;
          end else begin
            hwc_nxt = HW_FIRST;
            if (rem != '0) ph_nxt = PH_TOP_SKIP;
          end
        end
      end
      PH_TOP_SKIP: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          ph_nxt  = PH_TOP_WORDS;
          hwc_nxt = HW_FIRST;
        end
      end
      PH_MOVI_WORDS: begin
        if (movi_stop) begin
          ph_nxt = PH_DONE;
        end else begin
          ws_nxt  = ws_g;
          biw_nxt = biw_g;
          if (full) begin
            if (hwc == HW_FIRST) begin
              tag_nxt = ws_g;
              hwc_nxt = HW_SECOND;
            end else begin
              hwc_nxt = HW_FIRST;
              if (ws_g != '0) begin
                rem_nxt = ws_g;
                ph_nxt  = (tag[23:16] == video_tag_char) ? PH_MOVI_VIDEO : PH_MOVI_SKIP;
              end
            end
          end
        end
      end
      PH_MOVI_VIDEO, PH_MOVI_SKIP: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          ph_nxt  = PH_MOVI_WORDS;
          hwc_nxt = HW_FIRST;
        end
      end
      PH_DONE, PH_REJECT: begin
        ph_nxt = ph;
      end
    endcase
  end

  // outputs
  always_comb begin
    cls  = CLS_HEADER;
    last = 1'b0;
    unique case (ph) inside
      PH_HEADER, PH_TOP_WORDS: begin
        cls = CLS_HEADER;
      end
      PH_TOP_SKIP, PH_MOVI_SKIP: begin
        cls  = CLS_SKIP;
        last = (rem_dec == '0);
      end
      PH_MOVI_VIDEO: begin
        cls  = CLS_VIDEO;
        last = (rem_dec == '0);
      end
      PH_MOVI_WORDS: begin
        cls = movi_stop ? CLS_IGNORED : CLS_HEADER;
      end
      PH_DONE, PH_REJECT: begin
        cls = CLS_IGNORED;
      end
    endcase
    unique case (ph_nxt) inside
      PH_DONE:                                    status = ST_DONE;
      PH_REJECT:                                  status = ST_REJECT;
      PH_MOVI_WORDS, PH_MOVI_VIDEO, PH_MOVI_SKIP: status = ST_MOVI;
      PH_HEADER, PH_TOP_WORDS, PH_TOP_SKIP:       status = ST_SEARCH;
    endcase
  end

  assign result.out_byte     = item.data_byte;
  assign result.byte_class   = cls;
  assign result.payload_last = last;
  assign result.parse_status = status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_HEADER;
      biw_r  <= '0;
      ws_r   <= '0;
      tag_r  <= '0;
      rem_r  <= '0;
      fpos_r <= '0;
      mend_r <= '0;
      hwc_r  <= HW_FIRST;
    end else if (fire) begin
      ph_r   <= ph_nxt;
      biw_r  <= biw_nxt;
      ws_r   <= ws_nxt;
      tag_r  <= tag_nxt;
      rem_r  <= rem_nxt;
      fpos_r <= fpos_nxt;
      mend_r <= mend_nxt;
      hwc_r  <= hwc_nxt;
    end
  end

endmodule

>>> rtl/avidmx_out_reg.sv
// result register toward the output channel
module avidmx_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  avidmx_pkg::result_t result,
  output logic                take,
  output logic                out_valid,
  input  logic                out_stall,
  output avidmx_pkg::result_t out_result
);
  import avidmx_pkg::*;

  logic    valid_r;
  result_t result_r;

  assign take       = !valid_r || !out_stall;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1_valid) begin
      result_r <= result;
    end
  end

endmodule

>>> rtl/avi_riff_chunk_demux_top.sv
// channel   | direction | handshake        | payload
// ----------+-----------+------------------+----------------------------------------
// in_       | in        | valid / stall    | data_byte, file_start, stop_request
// out_      | out       | valid / stall    | out_byte, byte_class, payload_last,
//           |           |                  |   parse_status
// cfg_      | in        | valid / ready    | video_tag_char
//
// one word per cycle sustained while out_stall is low
// the rate is set by the single parse step between input and result register
// rst_n is synchronous: parser back to header search, video tag char to 'd'
// out_stall holds the result register and, once the input register is full, in_stall
// cfg_ready is always high; write only while the block is idle
module avi_riff_chunk_demux_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_file_start,
  input  logic       in_stop_request,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic [1:0] out_byte_class,
  output logic       out_payload_last,
  output logic [1:0] out_parse_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_video_tag_char
);
  import avidmx_pkg::*;

  `include "assert_macros.svh"

  logic [7:0] video_tag_char_r;
  item_t      in_item;
  item_t      s1_item;
  logic       s1_valid;
  logic       take;
  stage_ctl_t ctl;
  result_t    result;
  result_t    out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_tag_char_r <= VIDEO_CHAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      video_tag_char_r <= cfg_video_tag_char;
    end
  end

  assign in_item.data_byte    = in_data_byte;
  assign in_item.file_start   = in_file_start;
  assign in_item.stop_request = in_stop_request;

  avidmx_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  assign ctl.valid = s1_valid;
  assign ctl.take  = take;

  avidmx_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .item           (s1_item),
    .video_tag_char (video_tag_char_r),
    .result         (result)
  );

  avidmx_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .result     (result),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_out_byte     = out_result.out_byte;
  assign out_byte_class   = out_result.byte_class;
  assign out_payload_last = out_result.payload_last;
  assign out_parse_status = out_result.parse_status;

  `ASSERT_IMPLY(a_last_in_payload, clk, rst_n,
    out_valid && out_payload_last,
    out_byte_class == CLS_VIDEO || out_byte_class == CLS_SKIP,
    "payload_last outside a payload")
  `ASSERT_IMPLY(a_ignored_ends, clk, rst_n,
    out_valid && out_byte_class == CLS_IGNORED,
    out_parse_status == ST_DONE || out_parse_status == ST_REJECT,
    "ignored word while parsing is live")
  `ASSERT_IMPLY(a_video_in_movi, clk, rst_n,
    out_valid && out_byte_class == CLS_VIDEO,
    out_parse_status == ST_MOVI,
    "video word outside movi")
  `ASSERT_NEXT(a_stall_holds_stage, clk, rst_n,
    s1_valid && !take,
    s1_valid && $stable(s1_item),
    "input stage lost its word while blocked")

endmodule
